[src/salc_pkg.sv]
// Package of the set-associative LRU cache model: beat types, register indexes and codes.
package salc_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [1:0] CFG_BLOCK_BITS  = 2'd1;
    localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

    // Configuration reset values.
    localparam logic [2:0] RST_SET_BITS    = 3'd4;
    localparam logic [5:0] RST_BLOCK_BITS  = 6'd4;
    localparam logic [3:0] RST_WAYS_IN_USE = 4'd1;

    // Access kinds.
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_MODIFY = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // Input beat: one memory access.
    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] address;
    } t_in;

    // Output beat: counts of this access and running totals.
    typedef struct packed {
        logic [1:0]  hit_count;
        logic [1:0]  miss_count;
        logic [1:0]  evict_count;
        logic [31:0] total_hits;
        logic [31:0] total_misses;
        logic [31:0] total_evictions;
    } t_out;

endpackage

[src/set_assoc_lru_cache_sim_top.sv]
// Top level of the set-associative LRU cache tag store with hit, miss and eviction counters.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in: mode, address)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out: counts, totals)
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// An item passes through the address split, then for each of its n accesses (0, 1, or 2 for
// a modify) a set memory read, a scan of the W lines in use per set on the single shared tag
// comparator, and a row write-back, and last the output register load. The next item is
// accepted once the sequencer has returned to idle after the output register loads. Reset
// clears 2^MAX_SET_BITS row-valid flops at once; a row never written reads as empty. A
// finished beat waits in the output register while the next item runs; a full register
// stalls it.
module set_assoc_lru_cache_sim_top
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDRESS_BITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [5:0] i_cfg_data
);

    localparam int ROW_COUNT = 1 << MAX_SET_BITS;
    localparam int SET_IW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
    localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam logic [RANK_W-1:0] RANK_MAX  = RANK_W'(MAX_WAYS - 1);
    localparam logic [RANK_W:0]   RANK_FILL = (RANK_W + 1)'(MAX_WAYS);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SPLIT = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // Set memory: one row per set, and a row-valid flop per set.
    logic [MAX_WAYS-1:0][ADDRESS_BITS-1:0] mem_tag  [ROW_COUNT];
    logic [MAX_WAYS-1:0]                   mem_vld  [ROW_COUNT];
    logic [MAX_WAYS-1:0][RANK_W-1:0]       mem_rank [ROW_COUNT];
    logic [ROW_COUNT-1:0]                  r_row_valid;

    logic [2:0]              r_state;
    logic [2:0]              r_cfg_set;
    logic [5:0]              r_cfg_block;
    logic [3:0]              r_cfg_ways;
    logic [1:0]              r_mode;
    logic [ADDRESS_BITS-1:0] r_addr;
    logic [SET_IW-1:0]       r_set;
    logic [ADDRESS_BITS-1:0] r_tag;
    logic [WAY_W-1:0]        r_last;
    logic [1:0]              r_left;

    logic [MAX_WAYS-1:0][ADDRESS_BITS-1:0] r_rd_tag;
    logic [MAX_WAYS-1:0]                   r_rd_vld;
    logic [MAX_WAYS-1:0][RANK_W-1:0]       r_rd_rank;
    logic                                  r_rd_ok;

    logic              r_way;
    logic [WAY_W-1:0]  r_way_idx;
    logic              r_hit_f;
    logic [WAY_W-1:0]  r_hit_way;
    logic              r_inv_f;
    logic [WAY_W-1:0]  r_inv_way;
    logic [WAY_W-1:0]  r_vic_way;
    logic [RANK_W-1:0] r_best;

    logic [1:0]  r_hits;
    logic [1:0]  r_misses;
    logic [1:0]  r_evicts;
    logic [31:0] r_tot_hits;
    logic [31:0] r_tot_misses;
    logic [31:0] r_tot_evicts;

    logic r_out_valid;
    t_out r_out;
    logic w_load_out;

    // Address split: clamp the set bit count and the way count.
    logic [2:0]              w_s;
    logic [SET_IW:0]         w_mask_full;
    logic [ADDRESS_BITS-1:0] w_blk_shift;
    logic [6:0]              w_tag_amt;
    logic [WCNT_W-1:0]       w_eff_ways;

    always_comb begin
        if (int'(r_cfg_set) > MAX_SET_BITS) begin
            w_s = 3'(MAX_SET_BITS);
        end else begin
            w_s = r_cfg_set;
        end
        w_mask_full = ((SET_IW + 1)'(1) << w_s) - (SET_IW + 1)'(1);
        w_blk_shift = r_addr >> r_cfg_block;
        w_tag_amt   = 7'(w_s) + 7'(r_cfg_block);
        if (r_cfg_ways == 4'd0) begin
            w_eff_ways = WCNT_W'(1);
        end else if (int'(r_cfg_ways) > MAX_WAYS) begin
            w_eff_ways = WCNT_W'(MAX_WAYS);
        end else begin
            w_eff_ways = WCNT_W'(r_cfg_ways);
        end
    end

    // Row contents as seen by the scan: a row never written is empty.
    logic [MAX_WAYS-1:0]             w_vld;
    logic [MAX_WAYS-1:0][RANK_W-1:0] w_rank;

    assign w_vld  = r_rd_ok ? r_rd_vld : '0;
    assign w_rank = r_rd_ok ? r_rd_rank : '0;

    // Shared tag comparator on the way under scan.
    logic w_match;
    assign w_match = w_vld[r_way_idx] && (r_rd_tag[r_way_idx] == r_tag);

    // Outcome of the access and the LRU update of the row.
    logic                                  w_is_hit;
    logic                                  w_is_fill;
    logic [WAY_W-1:0]                      w_sel;
    logic [RANK_W:0]                       w_old;
    logic [MAX_WAYS-1:0][ADDRESS_BITS-1:0] w_new_tag;
    logic [MAX_WAYS-1:0]                   w_new_vld;
    logic [MAX_WAYS-1:0][RANK_W-1:0]       w_new_rank;

    always_comb begin
        w_is_hit  = r_hit_f;
        w_is_fill = !r_hit_f && r_inv_f;
        if (r_hit_f) begin
            w_sel = r_hit_way;
            w_old = {1'b0, w_rank[r_hit_way]};
        end else if (r_inv_f) begin
            w_sel = r_inv_way;
            w_old = RANK_FILL;
        end else begin
            w_sel = r_vic_way;
            w_old = {1'b0, r_best};
        end
        w_new_tag = r_rd_tag;
        w_new_vld = w_vld;
        for (int w = 0; w < MAX_WAYS; w++) begin
            w_new_rank[w] = w_rank[w];
            if (WAY_W'(w) == w_sel) begin
                w_new_rank[w] = '0;
                w_new_vld[w]  = 1'b1;
                if (!w_is_hit) begin
                    w_new_tag[w] = r_tag;
                end
            end else if ((WAY_W'(w) <= r_last) && w_vld[w] &&
                         ({1'b0, w_rank[w]} < w_old) && (w_rank[w] < RANK_MAX)) begin
                w_new_rank[w] = w_rank[w] + RANK_W'(1);
            end
        end
    end

    // Saturating increment of a running total.
    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The finished beat moves out once the previous beat has left.
    assign w_load_out = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // Set memory write-back and registered read.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPD) begin
            mem_tag[r_set]  <= w_new_tag;
            mem_vld[r_set]  <= w_new_vld;
            mem_rank[r_set] <= w_new_rank;
        end
        if (r_state == ST_READ) begin
            r_rd_tag  <= mem_tag[r_set];
            r_rd_vld  <= mem_vld[r_set];
            r_rd_rank <= mem_rank[r_set];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_set   <= RST_SET_BITS;
            r_cfg_block <= RST_BLOCK_BITS;
            r_cfg_ways  <= RST_WAYS_IN_USE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SET_BITS:    r_cfg_set   <= i_cfg_data[2:0];
                CFG_BLOCK_BITS:  r_cfg_block <= i_cfg_data;
                CFG_WAYS_IN_USE: r_cfg_ways  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Output register: loads a finished beat and empties when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out.hit_count       <= r_hits;
            r_out.miss_count      <= r_misses;
            r_out.evict_count     <= r_evicts;
            r_out.total_hits      <= r_tot_hits;
            r_out.total_misses    <= r_tot_misses;
            r_out.total_evictions <= r_tot_evicts;
            r_out_valid           <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Sequencer, scan registers and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_row_valid  <= '0;
            r_tot_hits   <= '0;
            r_tot_misses <= '0;
            r_tot_evicts <= '0;
            r_way        <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_mode   <= i_in_data.mode;
                        r_addr   <= i_in_data.address[ADDRESS_BITS-1:0];
                        r_hits   <= '0;
                        r_misses <= '0;
                        r_evicts <= '0;
                        r_state  <= ST_SPLIT;
                    end
                end
                ST_SPLIT: begin
                    r_set  <= w_blk_shift[SET_IW-1:0] & w_mask_full[SET_IW-1:0];
                    r_tag  <= r_addr >> w_tag_amt;
                    r_last <= WAY_W'(w_eff_ways - WCNT_W'(1));
                    case (r_mode)
                        MODE_MODIFY: begin
                            r_left  <= 2'd2;
                            r_state <= ST_READ;
                        end
                        MODE_NONE: begin
                            r_left  <= 2'd0;
                            r_state <= ST_DONE;
                        end
                        default: begin
                            r_left  <= 2'd1;
                            r_state <= ST_READ;
                        end
                    endcase
                end
                ST_READ: begin
                    r_rd_ok   <= r_row_valid[r_set];
                    r_way_idx <= '0;
                    r_way     <= 1'b1;
                    r_hit_f   <= 1'b0;
                    r_inv_f   <= 1'b0;
                    r_state   <= ST_SCAN;
                end
                ST_SCAN: begin
                    // One way per cycle: first hit, first empty line, oldest line.
                    if (!r_hit_f && w_match) begin
                        r_hit_f   <= 1'b1;
                        r_hit_way <= r_way_idx;
                    end
                    if (!r_inv_f && !w_vld[r_way_idx]) begin
                        r_inv_f   <= 1'b1;
                        r_inv_way <= r_way_idx;
                    end
                    if (r_way || (w_rank[r_way_idx] > r_best)) begin
                        r_best    <= w_rank[r_way_idx];
                        r_vic_way <= r_way_idx;
                    end
                    r_way <= 1'b0;
                    if (r_way_idx == r_last) begin
                        r_state <= ST_UPD;
                    end else begin
                        r_way_idx <= r_way_idx + WAY_W'(1);
                    end
                end
                ST_UPD: begin
                    r_row_valid[r_set] <= 1'b1;
                    if (w_is_hit) begin
                        r_hits     <= r_hits + 2'd1;
                        r_tot_hits <= sat_inc(r_tot_hits);
                    end else begin
                        r_misses     <= r_misses + 2'd1;
                        r_tot_misses <= sat_inc(r_tot_misses);
                        if (!w_is_fill) begin
                            r_evicts     <= r_evicts + 2'd1;
                            r_tot_evicts <= sat_inc(r_tot_evicts);
                        end
                    end
                    r_left <= r_left - 2'd1;
                    if (r_left == 2'd1) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_READ;
                    end
                end
                ST_DONE: begin
                    // Wait here until the output register takes the beat.
                    if (w_load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[test/tb_set_assoc_lru_cache_sim_top.sv]
// Testbench of the set-associative LRU cache top level: predicted counts checked per beat.
module tb_set_assoc_lru_cache_sim_top;
    import salc_pkg::*;

    localparam int SET_COUNT    = 64;
    localparam int NUM_WAYS     = 8;
    localparam int SET_CAP      = 6;
    localparam int SETTLE_WAIT  = 30;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_ITEMS   = 150;
    localparam int LONG_HOLD    = 400;

    // Outcome of one access to the tag store.
    typedef enum logic [1:0] {ACC_HIT, ACC_FILL, ACC_EVICT} t_access_outcome;

    // Tag store predictor and the queue of result beats it expects.
    class lru_tag_board;
        logic [2:0]  set_bits;
        logic [5:0]  block_bits;
        logic [3:0]  ways_in_use;
        bit          line_valid[SET_COUNT * NUM_WAYS];
        logic [63:0] line_tag[SET_COUNT * NUM_WAYS];
        logic [2:0]  line_rank[SET_COUNT * NUM_WAYS];
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] evict_total;
        t_out        expected_counts[$];
        int          failures;
        int          checked;

        function new();
            set_bits    = RST_SET_BITS;
            block_bits  = RST_BLOCK_BITS;
            ways_in_use = RST_WAYS_IN_USE;
            foreach (line_valid[i]) begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
                line_rank[i]  = '0;
            end
            hit_total   = '0;
            miss_total  = '0;
            evict_total = '0;
            failures    = 0;
            checked     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [5:0] val);
            case (idx)
                CFG_SET_BITS:    set_bits = val[2:0];
                CFG_BLOCK_BITS:  block_bits = val;
                CFG_WAYS_IN_USE: ways_in_use = val[3:0];
                default: ;
            endcase
        endfunction

        // Make one line the most recent; more recent valid lines age by one.
        function void promote(int base, int ways, int sel, int old_rank);
            for (int w = 0; w < ways; w++) begin
                if (w != sel && line_valid[base + w] && int'(line_rank[base + w]) < old_rank
                        && line_rank[base + w] < 3'(NUM_WAYS - 1)) begin
                    line_rank[base + w] = line_rank[base + w] + 3'd1;
                end
            end
            line_rank[base + sel] = '0;
        endfunction

        function t_access_outcome predict_access(logic [63:0] addr);
            int          s;
            int          ways;
            int          base;
            int          victim;
            logic [63:0] set_field;
            logic [63:0] tag;
            logic [2:0]  best;
            s    = (set_bits > SET_CAP) ? SET_CAP : int'(set_bits);
            ways = (ways_in_use == 0) ? 1 : ((ways_in_use > NUM_WAYS) ? NUM_WAYS
                                                                      : int'(ways_in_use));
            set_field = (addr >> block_bits) & ((64'd1 << s) - 64'd1);
            tag  = (s + int'(block_bits) >= 64) ? 64'd0 : (addr >> (s + int'(block_bits)));
            base = int'(set_field[5:0]) * NUM_WAYS;
            // The lowest matching valid line is the hit.
            for (int w = 0; w < ways; w++) begin
                if (line_valid[base + w] && line_tag[base + w] == tag) begin
                    promote(base, ways, w, int'(line_rank[base + w]));
                    return ACC_HIT;
                end
            end
            // Fill the first empty line.
            for (int w = 0; w < ways; w++) begin
                if (!line_valid[base + w]) begin
                    line_valid[base + w] = 1'b1;
                    line_tag[base + w]   = tag;
                    promote(base, ways, w, NUM_WAYS);
                    return ACC_FILL;
                end
            end
            // Evict the oldest line; ties go to the lowest line number.
            victim = 0;
            best   = line_rank[base];
            for (int w = 1; w < ways; w++) begin
                if (line_rank[base + w] > best) begin
                    best   = line_rank[base + w];
                    victim = w;
                end
            end
            line_tag[base + victim] = tag;
            promote(base, ways, victim, int'(best));
            return ACC_EVICT;
        endfunction

        function void note_access(t_in item);
            int              n;
            int              hits;
            int              misses;
            int              evicts;
            t_access_outcome outcome;
            t_out            e;
            n      = (item.mode == MODE_MODIFY) ? 2 : ((item.mode == MODE_NONE) ? 0 : 1);
            hits   = 0;
            misses = 0;
            evicts = 0;
            for (int k = 0; k < n; k++) begin
                outcome = predict_access(item.address);
                if (outcome == ACC_HIT) begin
                    hits++;
                    if (hit_total != '1) hit_total++;
                end else begin
                    misses++;
                    if (miss_total != '1) miss_total++;
                    if (outcome == ACC_EVICT) begin
                        evicts++;
                        if (evict_total != '1) evict_total++;
                    end
                end
            end
            e.hit_count       = 2'(hits);
            e.miss_count      = 2'(misses);
            e.evict_count     = 2'(evicts);
            e.total_hits      = hit_total;
            e.total_misses    = miss_total;
            e.total_evictions = evict_total;
            expected_counts.push_back(e);
        endfunction

        function void check_result(t_out got);
            t_out e;
            checked++;
            if (expected_counts.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("Unexpected result beat: %p", got);
                return;
            end
            e = expected_counts.pop_front();
            if (got.hit_count != e.hit_count || got.miss_count != e.miss_count
                    || got.evict_count != e.evict_count || got.total_hits != e.total_hits
                    || got.total_misses != e.total_misses
                    || got.total_evictions != e.total_evictions) begin
                failures++;
                if (failures <= 10)
                    $display("Mismatch on beat %0d: expected %p, got %p", checked, e, got);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in        i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out       o_out_data;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = CFG_SET_BITS;
    logic [5:0] i_cfg_data = '0;

    lru_tag_board book = new();
    int          sent_items = 0;
    bit          calm = 1'b0;
    int          hold_left = 0;
    bit          long_hold_done = 1'b0;
    int          cycles = 0;

    set_assoc_lru_cache_sim_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Output side: random stall bursts, one long hold-off, and no stalls near the end.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!long_hold_done && book.checked >= 150) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            i_out_ready    <= 1'b0;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            hold_left   <= $urandom_range(0, 13);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Check every result beat that is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            book.check_result(o_out_data);
    end

    // Offer one access beat, with an occasional idle burst before it.
    task automatic send_access(input logic [1:0] mode, input logic [63:0] addr);
        t_in item;
        int  gap;
        item.mode    = mode;
        item.address = addr;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        book.note_access(item);
        sent_items++;
    endtask

    // Drain all expected beats, then let the block finish any access still in flight.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (book.expected_counts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        book.write_reg(idx, val);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input logic [5:0] sb, input logic [5:0] bb,
                                input logic [5:0] wy);
        wait_idle();
        write_reg(CFG_SET_BITS, sb);
        write_reg(CFG_BLOCK_BITS, bb);
        write_reg(CFG_WAYS_IN_USE, wy);
    endtask

    // Mostly addresses built from a few tags and sets so that hits and evictions occur.
    function automatic logic [63:0] pick_address();
        int          s;
        int          b;
        logic [63:0] noise;
        s     = (book.set_bits > SET_CAP) ? SET_CAP : int'(book.set_bits);
        b     = int'(book.block_bits);
        noise = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0)
            return noise;
        return (noise & ((64'd1 << b) - 64'd1))
             | (64'($urandom_range(0, 3)) << b)
             | (64'($urandom_range(0, int'(book.ways_in_use) + 3)) << (s + b));
    endfunction

    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return MODE_NONE;
        if (r < 8) return MODE_LOAD;
        if (r < 14) return MODE_STORE;
        return MODE_MODIFY;
    endfunction

    initial begin : stimulus
        int         phase;
        int         phase_len;
        logic [5:0] sb;
        logic [5:0] bb;
        logic [5:0] wy;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry: every mode, address extremes, and a repeat that hits.
        send_access(MODE_LOAD, 64'd0);
        send_access(MODE_STORE, '1);
        send_access(MODE_MODIFY, 64'h0123_4567_89AB_CDEF);
        send_access(MODE_NONE, 64'd0);
        send_access(MODE_LOAD, 64'd0);

        // Two lines get the same tag while the second way is hidden; the lower one hits.
        set_geometry(6'd0, 6'd0, 6'd2);
        send_access(MODE_LOAD, 64'd4);
        send_access(MODE_LOAD, 64'd8);
        set_geometry(6'd0, 6'd0, 6'd1);
        send_access(MODE_LOAD, 64'd8);
        set_geometry(6'd0, 6'd0, 6'd2);
        send_access(MODE_LOAD, 64'd8);
        send_access(MODE_MODIFY, 64'd4);
        send_access(MODE_STORE, 64'd8);

        // Set count above its cap, offset past the top bit, zero ways.
        set_geometry(6'd7, 6'd63, 6'd0);
        send_access(MODE_LOAD, '1);
        send_access(MODE_LOAD, 64'h8000_0000_0000_0000);
        send_access(MODE_MODIFY, 64'd0);

        // Set and offset bits together reach the address width; ways above their cap.
        set_geometry(6'd6, 6'd58, 6'd15);
        send_access(MODE_LOAD, '1);
        send_access(MODE_STORE, 64'h0400_0000_0000_0000);

        // Full associativity in one set: eight fills, then the oldest line goes.
        set_geometry(6'd6, 6'd0, 6'd8);
        for (int t = 0; t < 9; t++)
            send_access(MODE_LOAD, 64'(t) << 6);

        // Random phases, each under its own geometry.
        phase = 0;
        while (sent_items < RANDOM_ITEMS + 26) begin
            case (phase)
                0: begin sb = 6'd6; bb = 6'd0;  wy = 6'd8;  end
                1: begin sb = 6'd0; bb = 6'd63; wy = 6'd1;  end
                2: begin sb = 6'd7; bb = 6'd2;  wy = 6'd15; end
                3: begin sb = 6'd1; bb = 6'd40; wy = 6'd0;  end
                default: begin
                    sb = 6'($urandom_range(0, 7));
                    bb = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(9, 63))
                                                     : 6'($urandom_range(0, 8));
                    wy = 6'($urandom_range(0, 15));
                end
            endcase
            set_geometry(sb, bb, wy);
            phase_len = $urandom_range(60, 120);
            for (int k = 0; k < phase_len; k++) begin
                if (sent_items >= RANDOM_ITEMS + 26 - CALM_ITEMS)
                    calm = 1'b1;
                send_access(pick_mode(), pick_address());
            end
            phase++;
        end

        wait_idle();
        if (book.failures == 0 && book.expected_counts.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
